// ----- rtl/core/stk_pkg.sv -----
// ---------------------------------------------------------------------------
// stk_pkg: shared types and constants of the key stack
// Stack depth, derived widths, command and status codes, sequencer types.
// ---------------------------------------------------------------------------
package stk_pkg;

   localparam int DEPTH   = 16;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int KEY_W   = 8;
   localparam int LEVEL_W = 5;
   localparam int STAT_W  = 2;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [STAT_W-1:0]  status_type;

   localparam logic CMD_PUSH   = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam status_type STATUS_DONE      = 2'd0;
   localparam status_type STATUS_FULL      = 2'd1;
   localparam status_type STATUS_EMPTY     = 2'd2;
   localparam status_type STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT
   } seq_state_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      key_type  wr_data;
      addr_type rd_addr;
   } ram_ctrl_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      cnt_type    level;
   } result_type;

endpackage

// ----- rtl/core/stack_with_remove_by_key.sv -----
// ---------------------------------------------------------------------------
// stack_with_remove_by_key: bounded LIFO of byte keys with delete by value
// Push on top, or remove the topmost entry equal to a key while keeping the
// order of the entries above it. One result transaction per command.
// ---------------------------------------------------------------------------
// A push, and any refused command, completes when accepted: the result
// is loaded into the output register at the edge that accepts the
// transaction. A remove scans the stack from the top, one entry per cycle
// through the single read port of the entry RAM and one key comparator,
// then moves the entries above the match down one place per cycle through
// the same port. The input stalls while a remove is in progress and while
// the output register holds a result that is itself being stalled. Status
// codes: done, refused full, refused empty, key not found.
// ---------------------------------------------------------------------------
module stack_with_remove_by_key (
   input  logic                          clock,
   input  logic                          reset,
   // command transactions
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [stk_pkg::KEY_W-1:0]     req_key,
   // result transactions
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [stk_pkg::STAT_W-1:0]    rsp_status,
   output logic [stk_pkg::LEVEL_W-1:0]   rsp_level
);

   stk_pkg::ram_ctrl_type ram;
   stk_pkg::result_type   result;
   stk_pkg::key_type      rd_data;
   logic                  slot_free;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [stk_pkg::STAT_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [stk_pkg::LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;

   // output register is free, or drains at this edge
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // sequencer: command decode, search and compaction
   stk_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_key     (req_key),
      .req_stall   (req_stall),
      .slot_free   (slot_free),
      .rd_data     (rd_data),
      .ram         (ram),
      .result      (result)
   );

   // entry storage, index 0 is the bottom of the stack
   stk_ram #(
      .WIDTH (stk_pkg::KEY_W),
      .DEPTH (stk_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram.wr_en),
      .wr_addr (ram.wr_addr),
      .wr_data (ram.wr_data),
      .rd_addr (ram.rd_addr),
      .rd_data (rd_data)
   );

   // result register: loaded on completion, cleared when taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_level_in  = rsp_level_ff;
      priority if (result.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result.status;
         // level reported modulo the field width
         rsp_level_in  = stk_pkg::LEVEL_W'(result.level);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_level  = rsp_level_ff;

   // a completing command never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> slot_free)
      else $error("result register overwritten");

   // a refused push reports a full stack
   a_full_level: assert property (@(posedge clock) disable iff (reset)
      result.valid && (result.status == stk_pkg::STATUS_FULL)
      |-> (result.level == stk_pkg::CNT_W'(stk_pkg::DEPTH)))
      else $error("full refusal with stack not full");

   // a refused remove reports an empty stack
   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      result.valid && (result.status == stk_pkg::STATUS_EMPTY)
      |-> (result.level == '0))
      else $error("empty refusal with entries held");

   // an accepted command never leaves the level above the depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (int'(result.level) <= stk_pkg::DEPTH))
      else $error("level beyond depth");

endmodule

// ----- rtl/core/stk_ram.sv -----
// ---------------------------------------------------------------------------
// stk_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module stk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- rtl/core/stk_seq.sv -----
// ---------------------------------------------------------------------------
// stk_seq: command sequencer of the key stack
// Pushes at the edge that accepts them; removes by scanning down one entry a cycle through
// the shared read port and key comparator, then compacting in place.
// ---------------------------------------------------------------------------
module stk_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_command,
   input  stk_pkg::key_type      req_key,
   output logic                  req_stall,
   input  logic                  slot_free,
   input  stk_pkg::key_type      rd_data,
   output stk_pkg::ram_ctrl_type ram,
   output stk_pkg::result_type   result
);

   stk_pkg::seq_state_type state_ff, state_in;
   stk_pkg::cnt_type       level_ff, level_in;
   stk_pkg::addr_type      pos_ff, pos_in;
   stk_pkg::key_type       key_ff, key_in;
   logic                   hit;
   stk_pkg::cnt_type       pos_plus1;
   stk_pkg::cnt_type       pos_plus2;

   assign hit       = (rd_data == key_ff);
   assign pos_plus1 = stk_pkg::CNT_W'(pos_ff) + stk_pkg::CNT_W'(1);
   assign pos_plus2 = stk_pkg::CNT_W'(pos_ff) + stk_pkg::CNT_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stk_pkg::ST_IDLE;
         level_ff <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
      end
      pos_ff <= pos_in;
      key_ff <= key_in;
   end

   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      pos_in         = pos_ff;
      key_in         = key_ff;
      ram.wr_en      = 1'b0;
      ram.wr_addr    = pos_ff;
      ram.wr_data    = rd_data;
      ram.rd_addr    = pos_ff;
      result.valid   = 1'b0;
      result.status  = stk_pkg::STATUS_DONE;
      result.level   = level_ff;
      req_stall      = (state_ff != stk_pkg::ST_IDLE) || !slot_free;

      unique case (state_ff)
         stk_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               if (req_command == stk_pkg::CMD_PUSH) begin
                  result.valid = 1'b1;
                  if (level_ff == stk_pkg::CNT_W'(stk_pkg::DEPTH)) begin
                     result.status = stk_pkg::STATUS_FULL;
                  end else begin
                     ram.wr_en    = 1'b1;
                     ram.wr_addr  = stk_pkg::ADDR_W'(level_ff);
                     ram.wr_data  = req_key;
                     level_in     = level_ff + stk_pkg::CNT_W'(1);
                     result.level = level_in;
                  end
               end else if (level_ff == '0) begin
                  result.valid  = 1'b1;
                  result.status = stk_pkg::STATUS_EMPTY;
               end else begin
                  // start at the top entry
                  ram.rd_addr = stk_pkg::ADDR_W'(level_ff - stk_pkg::CNT_W'(1));
                  pos_in      = ram.rd_addr;
                  key_in      = req_key;
                  state_in    = stk_pkg::ST_SEARCH;
               end
            end
         end

         stk_pkg::ST_SEARCH: begin
            // rd_data holds the entry at pos_ff
            if (hit) begin
               if (pos_plus1 == level_ff) begin
                  level_in     = level_ff - stk_pkg::CNT_W'(1);
                  result.valid = 1'b1;
                  result.level = level_in;
                  state_in     = stk_pkg::ST_IDLE;
               end else begin
                  ram.rd_addr = stk_pkg::ADDR_W'(pos_plus1);
                  state_in    = stk_pkg::ST_SHIFT;
               end
            end else if (pos_ff == '0) begin
               result.valid  = 1'b1;
               result.status = stk_pkg::STATUS_NOT_FOUND;
               state_in      = stk_pkg::ST_IDLE;
            end else begin
               ram.rd_addr = pos_ff - stk_pkg::ADDR_W'(1);
               pos_in      = ram.rd_addr;
            end
         end

         stk_pkg::ST_SHIFT: begin
            // rd_data holds the entry at pos_ff + 1, move it down
            ram.wr_en   = 1'b1;
            ram.wr_addr = pos_ff;
            ram.wr_data = rd_data;
            if (pos_plus2 == level_ff) begin
               level_in     = level_ff - stk_pkg::CNT_W'(1);
               result.valid = 1'b1;
               result.level = level_in;
               state_in     = stk_pkg::ST_IDLE;
            end else begin
               ram.rd_addr = stk_pkg::ADDR_W'(pos_plus2);
               pos_in      = stk_pkg::ADDR_W'(pos_plus1);
            end
         end

         default: begin
            state_in = stk_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
